/* hw/rtl/csv_field_tokenizer_unit_defines.svh */
// Assertion macros used by the checker file of the CSV field tokenizer.
`ifndef CSV_FIELD_TOKENIZER_UNIT_DEFINES_SVH
`define CSV_FIELD_TOKENIZER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSVT_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("csvt assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CSVT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("csvt assertion failed");

`endif

/* hw/rtl/csvt_pkg.sv */
// Types and constants of the CSV field tokenizer.
package csvt_pkg;

  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChQuote = 8'h22;

  localparam logic KindContent  = 1'b0;
  localparam logic KindFieldEnd = 1'b1;

  // Result queue geometry.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;
  localparam int unsigned QCntW  = 3;

  typedef enum logic [4:0] {
    ModeStart  = 5'b00001,
    ModePlain  = 5'b00010,
    ModeQuoted = 5'b00100,
    ModeQPend  = 5'b01000,
    ModeDrop   = 5'b10000
  } csvt_mode_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } csvt_in_t;

  typedef struct packed {
    logic       item_kind;
    logic [7:0] content_byte;
    logic       row_done;
    logic       unterminated_quote;
    logic       last_of_run;
  } csvt_out_t;

  typedef struct packed {
    logic [1:0] count;
    csvt_out_t  res0;
    csvt_out_t  res1;
    csvt_mode_e mode;
    logic       cr_held;
  } csvt_step_t;

endpackage

/* hw/rtl/csvt_parse.sv */
// Combinational parse step: one item and the current state give up to two results.
module csvt_parse
  import csvt_pkg::*;
(
  input  csvt_in_t   item_i,
  input  csvt_mode_e mode_i,
  input  logic       cr_held_i,
  output csvt_step_t step_o
);

  function automatic csvt_out_t mk(logic kind, logic [7:0] b, logic row, logic err);
    csvt_out_t r;
    r.item_kind          = kind;
    r.content_byte       = b;
    r.row_done           = row;
    r.unterminated_quote = err;
    r.last_of_run        = 1'b0;
    return r;
  endfunction

  logic [7:0] b;
  // Handling of a byte in an unquoted field.
  csvt_out_t  pb_res;
  logic       pb_emit;
  csvt_mode_e pb_mode;
  // Handling of a byte after a closing quote.
  csvt_out_t  db_res;
  logic       db_emit;
  csvt_mode_e db_mode;
  csvt_step_t s;

  assign b = item_i.text_byte;

  always_comb begin
    pb_res  = mk(KindContent, b, 1'b0, 1'b0);
    pb_emit = 1'b1;
    pb_mode = ModePlain;
    if (b == ChComma) begin
      pb_res  = mk(KindFieldEnd, 8'h00, 1'b0, 1'b0);
      pb_mode = ModeStart;
    end else if (b == ChLf) begin
      pb_res  = mk(KindFieldEnd, 8'h00, 1'b1, 1'b0);
      pb_mode = ModeStart;
    end else if (b == ChCr) begin
      pb_emit = 1'b0;
    end
  end

  always_comb begin
    db_res  = mk(KindFieldEnd, 8'h00, 1'b0, 1'b0);
    db_emit = 1'b1;
    db_mode = ModeStart;
    if (b == ChLf) begin
      db_res = mk(KindFieldEnd, 8'h00, 1'b1, 1'b0);
    end else if (b != ChComma) begin
      db_emit = 1'b0;
      db_mode = ModeDrop;
    end
  end

  always_comb begin
    s.count   = 2'd0;
    s.res0    = mk(KindContent, 8'h00, 1'b0, 1'b0);
    s.res1    = mk(KindContent, 8'h00, 1'b0, 1'b0);
    s.mode    = mode_i;
    s.cr_held = cr_held_i;
    if (item_i.end_of_text) begin
      s.mode    = ModeStart;
      s.cr_held = 1'b0;
      if (mode_i == ModePlain && cr_held_i) begin
        s.res0  = mk(KindContent, ChCr, 1'b0, 1'b0);
        s.res1  = mk(KindFieldEnd, 8'h00, 1'b1, 1'b0);
        s.count = 2'd2;
      end else begin
        s.res0  = mk(KindFieldEnd, 8'h00, 1'b1, mode_i == ModeQuoted);
        s.count = 2'd1;
      end
    end else begin
      case (mode_i)
        ModePlain: begin
          if (cr_held_i && b == ChLf) begin
            // CR LF pair ends the row; the CR is not content.
            s.res0    = mk(KindFieldEnd, 8'h00, 1'b1, 1'b0);
            s.count   = 2'd1;
            s.mode    = ModeStart;
            s.cr_held = 1'b0;
          end else if (cr_held_i) begin
            // A held CR without LF turns into content ahead of this byte.
            s.res0    = mk(KindContent, ChCr, 1'b0, 1'b0);
            s.res1    = pb_res;
            s.count   = pb_emit ? 2'd2 : 2'd1;
            s.mode    = pb_mode;
            s.cr_held = (b == ChCr);
          end else begin
            s.res0    = pb_res;
            s.count   = {1'b0, pb_emit};
            s.mode    = pb_mode;
            s.cr_held = (b == ChCr);
          end
        end
        ModeQuoted: begin
          if (b == ChQuote) begin
            s.mode = ModeQPend;
          end else begin
            s.res0  = mk(KindContent, b, 1'b0, 1'b0);
            s.count = 2'd1;
          end
        end
        ModeQPend: begin
          if (b == ChQuote) begin
            s.res0  = mk(KindContent, ChQuote, 1'b0, 1'b0);
            s.count = 2'd1;
            s.mode  = ModeQuoted;
          end else begin
            s.res0  = db_res;
            s.count = {1'b0, db_emit};
            s.mode  = db_mode;
          end
        end
        ModeDrop: begin
          s.res0  = db_res;
          s.count = {1'b0, db_emit};
          s.mode  = db_mode;
        end
        default: begin
          s.cr_held = 1'b0;
          if (b == ChQuote) begin
            s.mode = ModeQuoted;
          end else begin
            s.res0    = pb_res;
            s.count   = {1'b0, pb_emit};
            s.mode    = pb_mode;
            s.cr_held = (b == ChCr);
          end
        end
      endcase
    end
    if (s.count == 2'd2) begin
      s.res1.last_of_run = 1'b1;
    end else begin
      s.res0.last_of_run = 1'b1;
    end
  end

  assign step_o = s;

endmodule

/* hw/rtl/csv_field_tokenizer_unit.sv */
// Top level of the streaming CSV field tokenizer.
//
//   channel | direction | payload    | handshake
//   in      | input     | csvt_in_t  | in_valid_i / in_stall_o
//   out     | output    | csvt_out_t | out_valid_o / out_stall_i
//
// An item is registered, parsed combinationally and its zero to two results are
// written into a four-entry result queue; the queue feeds the output port.
// One item per cycle is taken while the queue holds at most two results.
// Reset returns the parser to field start and empties the queue.
// Output stalls reach the input only through the queue fill level.
module csv_field_tokenizer_unit
  import csvt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  csvt_in_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output csvt_out_t out_item_o
);

  logic             in_valid_q;
  csvt_in_t         in_q;
  csvt_mode_e       mode_q;
  logic             cr_held_q;
  csvt_out_t        queue_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q, cnt_d;
  csvt_step_t       step;
  logic             adv, in_take, pop;

  csvt_parse u_parse (
    .item_i   (in_q),
    .mode_i   (mode_q),
    .cr_held_i(cr_held_q),
    .step_o   (step)
  );

  // The parsed item moves on only when the queue has room for two results.
  assign adv        = in_valid_q && (cnt_q <= QCntW'(QDepth - 2));
  assign in_stall_o = in_valid_q && !adv;
  assign in_take    = in_valid_i && !in_stall_o;

  assign out_valid_o = (cnt_q != '0);
  assign out_item_o  = queue_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;

  always_comb begin
    cnt_d = cnt_q;
    if (adv) begin
      cnt_d = cnt_d + QCntW'(step.count);
    end
    if (pop) begin
      cnt_d = cnt_d - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      mode_q     <= ModeStart;
      cr_held_q  <= 1'b0;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      cnt_q      <= '0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (adv) begin
        in_valid_q <= 1'b0;
      end
      if (adv) begin
        mode_q    <= step.mode;
        cr_held_q <= step.cr_held;
        wr_ptr_q  <= wr_ptr_q + QPtrW'(step.count);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_item_i;
    end
    if (adv && step.count != 2'd0) begin
      queue_q[wr_ptr_q] <= step.res0;
    end
    if (adv && step.count == 2'd2) begin
      queue_q[wr_ptr_q + QPtrW'(1)] <= step.res1;
    end
  end

endmodule

/* hw/rtl/csvt_checker.sv */
// Port-level checker of the CSV field tokenizer and its bind statement.
`include "csv_field_tokenizer_unit_defines.svh"

module csvt_checker
  import csvt_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_i,
  input logic      out_stall_i,
  input csvt_out_t out_item_i
);

  `CSVT_ASSERT_NEXT(a_out_valid_holds, clk_i, rst_ni, out_valid_i && out_stall_i, out_valid_i)
  `CSVT_ASSERT_NEXT(a_out_item_holds, clk_i, rst_ni, out_valid_i && out_stall_i, $stable(out_item_i))
  `CSVT_ASSERT_NOW(a_end_has_no_byte, clk_i, rst_ni, out_valid_i && out_item_i.item_kind == KindFieldEnd, out_item_i.content_byte == 8'h00)
  `CSVT_ASSERT_NOW(a_content_no_flags, clk_i, rst_ni, out_valid_i && out_item_i.item_kind == KindContent, !out_item_i.row_done && !out_item_i.unterminated_quote)
  `CSVT_ASSERT_NOW(a_error_closes_row, clk_i, rst_ni, out_valid_i && out_item_i.unterminated_quote, out_item_i.row_done && out_item_i.last_of_run)

endmodule

bind csv_field_tokenizer_unit csvt_checker u_csvt_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_item_i (out_item_o)
);

/* dv/csvt_tb_pkg.sv */
// Scoreboard class that predicts and checks the CSV tokenizer output items.
`timescale 1ns / 1ps

package csvt_tb_pkg;
  import csvt_pkg::*;

  class csv_field_tracker;
    csvt_mode_e  mode;
    bit          cr_held;
    csvt_out_t   pending_tokens[$];
    csvt_out_t   item_tokens[$];
    int unsigned errors;

    function new();
      mode    = ModeStart;
      cr_held = 1'b0;
      errors  = 0;
    endfunction

    function void add_token(logic kind, logic [7:0] value, logic row, logic unterm);
      csvt_out_t t;
      t.item_kind          = kind;
      t.content_byte       = (kind == KindFieldEnd) ? 8'h00 : value;
      t.row_done           = row;
      t.unterminated_quote = unterm;
      t.last_of_run        = 1'b0;
      item_tokens.insert(item_tokens.size(), t);
    endfunction

    function void unquoted_byte(logic [7:0] value);
      if (value == ChComma) begin
        add_token(KindFieldEnd, 8'h00, 1'b0, 1'b0);
        mode = ModeStart;
      end else if (value == ChLf) begin
        add_token(KindFieldEnd, 8'h00, 1'b1, 1'b0);
        mode = ModeStart;
      end else if (value == ChCr) begin
        cr_held = 1'b1;
        mode    = ModePlain;
      end else begin
        add_token(KindContent, value, 1'b0, 1'b0);
        mode = ModePlain;
      end
    endfunction

    // Bytes between a closing quote and the next separator are thrown away.
    function void skipped_byte(logic [7:0] value);
      if (value == ChComma) begin
        add_token(KindFieldEnd, 8'h00, 1'b0, 1'b0);
        mode = ModeStart;
      end else if (value == ChLf) begin
        add_token(KindFieldEnd, 8'h00, 1'b1, 1'b0);
        mode = ModeStart;
      end else begin
        mode = ModeDrop;
      end
    endfunction

    function void note_text_item(csvt_in_t it);
      csvt_out_t  t;
      logic [7:0] b;
      b = it.text_byte;
      item_tokens.delete();
      if (it.end_of_text) begin
        if (mode == ModePlain && cr_held) add_token(KindContent, ChCr, 1'b0, 1'b0);
        add_token(KindFieldEnd, 8'h00, 1'b1, mode == ModeQuoted);
        mode    = ModeStart;
        cr_held = 1'b0;
      end else begin
        case (mode)
          ModePlain: begin
            if (cr_held) begin
              cr_held = 1'b0;
              if (b == ChLf) begin
                add_token(KindFieldEnd, 8'h00, 1'b1, 1'b0);
                mode = ModeStart;
              end else begin
                add_token(KindContent, ChCr, 1'b0, 1'b0);
                unquoted_byte(b);
              end
            end else begin
              unquoted_byte(b);
            end
          end
          ModeQuoted: begin
            if (b == ChQuote) mode = ModeQPend;
            else add_token(KindContent, b, 1'b0, 1'b0);
          end
          ModeQPend: begin
            if (b == ChQuote) begin
              add_token(KindContent, ChQuote, 1'b0, 1'b0);
              mode = ModeQuoted;
            end else begin
              skipped_byte(b);
            end
          end
          ModeDrop: skipped_byte(b);
          default: begin
            cr_held = 1'b0;
            if (b == ChQuote) mode = ModeQuoted;
            else unquoted_byte(b);
          end
        endcase
      end
      if (item_tokens.size() > 0) begin
        t = item_tokens.pop_back();
        t.last_of_run = 1'b1;
        item_tokens.insert(item_tokens.size(), t);
      end
      foreach (item_tokens[i]) pending_tokens.insert(pending_tokens.size(), item_tokens[i]);
    endfunction

    function string token_text(csvt_out_t t);
      return $sformatf("kind=%0d byte=%h row=%0d unterm=%0d last=%0d", t.item_kind,
                       t.content_byte, t.row_done, t.unterminated_quote, t.last_of_run);
    endfunction

    function void check_token(csvt_out_t got);
      csvt_out_t want;
      if (pending_tokens.size() == 0) begin
        errors++;
        if (errors <= 50)
          $display("%0t: unexpected token kind=%0d byte=%h row=%0d unterm=%0d last=%0d",
                   $time, got.item_kind, got.content_byte, got.row_done,
                   got.unterminated_quote, got.last_of_run);
        return;
      end
      want = pending_tokens.pop_front();
      if (got.item_kind !== want.item_kind || got.content_byte !== want.content_byte ||
          got.row_done !== want.row_done ||
          got.unterminated_quote !== want.unterminated_quote ||
          got.last_of_run !== want.last_of_run) begin
        errors++;
        if (errors <= 50)
          $display("%0t: token mismatch: expected %s, actual %s", $time,
                   token_text(want), token_text(got));
      end
    endfunction
  endclass

endpackage

/* dv/tb_top.sv */
// Top-level testbench of the CSV field tokenizer with stimulus and handshake drivers.
`timescale 1ns / 1ps

module tb_top;
  import csvt_pkg::*;
  import csvt_tb_pkg::*;

  localparam int unsigned PhaseItems = 550;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  csvt_in_t  in_item;
  logic      out_valid;
  logic      out_stall;
  csvt_out_t out_item;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned items_sent;

  csv_field_tracker tracker = new();

  csv_field_tokenizer_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Output side: check every accepted item, then pick the stall for the next cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_token(out_item);
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  task automatic send_item(input csvt_in_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    tracker.note_text_item(it);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] value);
    csvt_in_t it;
    it.text_byte   = value;
    it.end_of_text = 1'b0;
    send_item(it);
  endtask

  // The byte that travels with an end-of-data item is random; the block ignores it.
  task automatic send_end_of_text();
    csvt_in_t it;
    it.text_byte   = 8'($urandom_range(0, 255));
    it.end_of_text = 1'b1;
    send_item(it);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return ChComma;
      1: return ChCr;
      2: return ChLf;
      3: return ChQuote;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_field();
    int unsigned len;
    logic [7:0]  b;
    len = $urandom_range(0, 5);
    if ($urandom_range(0, 2) == 0) begin
      send_byte(ChQuote);
      repeat (len) begin
        b = pick_byte();
        send_byte(b);
        // Mostly double a quote inside the field; a lone one closes it early.
        if (b == ChQuote && $urandom_range(0, 7) != 0) send_byte(ChQuote);
      end
      if ($urandom_range(0, 11) != 0) send_byte(ChQuote);
      if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 3)) send_byte(pick_byte());
    end else begin
      repeat (len) begin
        b = pick_byte();
        if (b == ChComma || b == ChLf) b = 8'($urandom_range(8'h30, 8'h7A));
        send_byte(b);
      end
    end
  endtask

  task automatic send_record();
    int unsigned nf;
    nf = $urandom_range(1, 4);
    for (int unsigned f = 0; f < nf; f++) begin
      send_field();
      if (f + 1 < nf) send_byte(ChComma);
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3: send_byte(ChLf);
      4, 5, 6: begin
        send_byte(ChCr);
        send_byte(ChLf);
      end
      7: send_end_of_text();
      8: begin
        send_byte(ChComma);
        send_end_of_text();
      end
      default: send_byte(ChCr);
    endcase
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 8)) begin
      if ($urandom_range(0, 15) == 0) send_end_of_text();
      else send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Always waits for a clock edge so the idle valid settles before new items.
  task automatic wait_drained();
    do @(posedge clk); while (tracker.pending_tokens.size() != 0);
  endtask

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct);
    int unsigned start_count;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start_count    = items_sent;
    while (items_sent - start_count < PhaseItems) begin
      if ($urandom_range(0, 4) == 0) send_noise();
      else send_record();
    end
  endtask

  initial begin
    in_valid       = 1'b0;
    in_item        = '0;
    out_stall      = 1'b0;
    rst_n          = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    items_sent     = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed text: byte extremes, CRLF, quoted separators, doubled quotes,
    // dropped bytes after a closing quote, held CR before other bytes and end
    // of data, closed and unclosed quotes at end of data, trailing comma.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(ChCr);
    send_byte(ChLf);
    send_byte(ChQuote);
    send_byte(ChComma);
    send_byte(ChCr);
    send_byte(ChLf);
    send_byte(ChQuote);
    send_byte(ChQuote);
    send_byte(ChQuote);
    send_byte(8'h78);
    send_byte(ChComma);
    send_byte(8'h61);
    send_byte(ChQuote);
    send_byte(ChCr);
    send_byte(8'h62);
    send_byte(ChCr);
    send_end_of_text();
    send_byte(ChQuote);
    send_byte(ChQuote);
    send_end_of_text();
    send_byte(ChQuote);
    send_end_of_text();
    send_byte(ChComma);
    send_end_of_text();

    run_phase(6, 52);
    // Hold the input off until the output queue has fully drained once.
    in_valid <= 1'b0;
    wait_drained();
    run_phase(52, 6);
    run_phase(0, 0);
    in_valid <= 1'b0;

    wait_drained();
    repeat (20) @(posedge clk);
    if (tracker.pending_tokens.size() != 0)
      $display("%0t: %0d expected tokens never arrived", $time,
               tracker.pending_tokens.size());
    if (tracker.errors == 0 && tracker.pending_tokens.size() == 0) begin
      $display("PASS csv_field_tokenizer_unit");
    end else begin
      $display("FAIL csv_field_tokenizer_unit");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("%0t: timeout", $time);
    $display("FAIL csv_field_tokenizer_unit");
    $finish;
  end

endmodule
